### rtl/arpc_pkg.sv
// arpc_pkg: shared sizes, codes and structs of the arp responder with cache
// no dependencies; used by every module under rtl

package arpc_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int OPCODE_W  = 8;
  localparam int PTYPE_W   = 16;
  localparam int MAC_W     = 48;
  localparam int IP_W      = 32;
  localparam int STATUS_W  = 2;
  localparam int ENTRY_W   = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 48;

  localparam logic [OPCODE_W-1:0] OP_REQUEST     = 8'd1;
  localparam logic [OPCODE_W-1:0] OP_REPLY       = 8'd2;
  localparam logic [PTYPE_W-1:0]  ETHERTYPE_IPV4 = 16'h0800;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'd1;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic [1:0] {
    CMD_IGNORE = 2'd0,
    CMD_LEARN  = 2'd1,
    CMD_REPLY  = 2'd2
  } cmd_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE    = 2'd0,
    ST_UPDATED = 2'd1,
    ST_ADDED   = 2'd2,
    ST_FULL    = 2'd3
  } table_status_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
  } cmd_t;

  typedef struct packed {
    logic               send_reply;
    logic [MAC_W-1:0]   dest_mac;
    logic [IP_W-1:0]    dest_ip;
    table_status_e      status;
    logic [ENTRY_W-1:0] entry_index;
  } res_t;

endpackage

### rtl/arpc_front.sv
// arpc_front: accepts packet beats, holds own_ip and classifies each packet
// depends on arpc_pkg; feeds arpc_queue

module arpc_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [arpc_pkg::CFG_DAT_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [arpc_pkg::OPCODE_W-1:0]    opcode_i,
  input  logic [arpc_pkg::PTYPE_W-1:0]     proto_type_i,
  input  logic [arpc_pkg::MAC_W-1:0]       sender_mac_i,
  input  logic [arpc_pkg::IP_W-1:0]        sender_ip_i,
  input  logic [arpc_pkg::IP_W-1:0]        target_ip_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output arpc_pkg::cmd_t                   q_cmd_o
);

  logic [arpc_pkg::IP_W-1:0] own_ip_q, own_ip_d;

  // own_mac is not kept here
  always_comb begin
    own_ip_d = own_ip_q;
    if (cfg_we_i && cfg_idx_i == arpc_pkg::CFG_OWN_IP) begin
      own_ip_d = cfg_wdata_i[arpc_pkg::IP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q <= '0;
    end else begin
      own_ip_q <= own_ip_d;
    end
  end

  always_comb begin
    q_cmd_o.mac  = sender_mac_i;
    q_cmd_o.ip   = sender_ip_i;
    q_cmd_o.kind = arpc_pkg::CMD_IGNORE;
    case (opcode_i)
      arpc_pkg::OP_REQUEST: begin
        if (proto_type_i == arpc_pkg::ETHERTYPE_IPV4 && target_ip_i == own_ip_q) begin
          q_cmd_o.kind = arpc_pkg::CMD_REPLY;
        end
      end
      arpc_pkg::OP_REPLY: begin
        q_cmd_o.kind = arpc_pkg::CMD_LEARN;
      end
      default: begin
        q_cmd_o.kind = arpc_pkg::CMD_IGNORE;
      end
    endcase
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

### rtl/arpc_queue.sv
// arpc_queue: two-entry command queue between classifier and cache engine
// depends on arpc_pkg

module arpc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  arpc_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output arpc_pkg::cmd_t pop_cmd_o
);

  arpc_pkg::cmd_t                mem_q [arpc_pkg::QDEPTH];
  logic [arpc_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [arpc_pkg::QCNT_W-1:0]   cnt_q, cnt_d;

  assign full_o    = cnt_q == arpc_pkg::QCNT_W'(arpc_pkg::QDEPTH);
  assign valid_o   = cnt_q != '0;
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // depth is a power of two, pointers wrap on their own
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/arpc_back.sv
// arpc_back: cache engine, sequential mac search, learn/update and result register
// depends on arpc_pkg; takes commands from arpc_queue

module arpc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  arpc_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output arpc_pkg::res_t res_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_MISS = 4'b1000
  } state_e;

  state_e                       st_q, st_d;
  arpc_pkg::cmd_t               cmd_q, cmd_d;
  logic [arpc_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic [arpc_pkg::CNT_W-1:0]   count_q, count_d;
  arpc_pkg::res_t               res_q, res_d;
  logic                         out_valid_q, out_valid_d;

  logic [arpc_pkg::MAC_W-1:0]   mac_mem [arpc_pkg::TABLE_ENTRIES];
  logic [arpc_pkg::IP_W-1:0]    ip_mem  [arpc_pkg::TABLE_ENTRIES];
  logic [arpc_pkg::MAC_W-1:0]   mac_rd_q;
  logic                         we;
  logic [arpc_pkg::IDX_W-1:0]   wr_addr;
  logic                         last;
  logic                         reply;

  assign last  = (arpc_pkg::CNT_W'(idx_q) + 1'b1) == count_q;
  assign reply = cmd_q.kind == arpc_pkg::CMD_REPLY;

  always_comb begin
    st_d        = st_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    count_d     = count_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    q_pop_o     = 1'b0;
    we          = 1'b0;
    wr_addr     = idx_q;

    // finishing states fill the result; the address fields only for a reply
    res_d.send_reply = reply;
    res_d.dest_mac   = reply ? cmd_q.mac : '0;
    res_d.dest_ip    = reply ? cmd_q.ip : '0;

    case (st_q)
      S_IDLE: begin
        res_d = res_q;
        // start only with a free result slot so it is free at the finish
        if (q_valid_i && (!out_valid_q || out_ready_i)) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          idx_d   = '0;
          if (q_cmd_i.kind == arpc_pkg::CMD_IGNORE) begin
            res_d       = '0;
            out_valid_d = 1'b1;
          end else if (count_q == '0) begin
            st_d = S_MISS;
          end else begin
            st_d = S_READ;
          end
        end
      end
      S_READ: begin
        res_d = res_q;
        st_d  = S_CMP;
      end
      S_CMP: begin
        if (mac_rd_q == cmd_q.mac) begin
          we                = 1'b1;
          res_d.status      = arpc_pkg::ST_UPDATED;
          res_d.entry_index = arpc_pkg::ENTRY_W'(idx_q);
          out_valid_d       = 1'b1;
          st_d              = S_IDLE;
        end else if (last) begin
          res_d = res_q;
          st_d  = S_MISS;
        end else begin
          res_d = res_q;
          idx_d = idx_q + 1'b1;
          st_d  = S_READ;
        end
      end
      S_MISS: begin
        if (count_q < arpc_pkg::CNT_W'(arpc_pkg::TABLE_ENTRIES)) begin
          we                = 1'b1;
          wr_addr           = count_q[arpc_pkg::IDX_W-1:0];
          count_d           = count_q + 1'b1;
          res_d.status      = arpc_pkg::ST_ADDED;
          res_d.entry_index = arpc_pkg::ENTRY_W'(count_q[arpc_pkg::IDX_W-1:0]);
        end else begin
          res_d.status      = arpc_pkg::ST_FULL;
          res_d.entry_index = '0;
        end
        out_valid_d = 1'b1;
        st_d        = S_IDLE;
      end
      default: begin
        res_d = res_q;
        st_d  = S_IDLE;
      end
    endcase
  end

  // cache storage, registered read at the search index
  always_ff @(posedge clk_i) begin
    if (we) begin
      mac_mem[wr_addr] <= cmd_q.mac;
      ip_mem[wr_addr]  <= cmd_q.ip;
    end
    mac_rd_q <= mac_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= arpc_pkg::CNT_W'(arpc_pkg::TABLE_ENTRIES))
    else $error("entry count above table size");

  a_cmp_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_CMP) |-> $past(st_q == S_READ))
    else $error("compare without a preceding read");

  a_add_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_MISS && count_q < arpc_pkg::CNT_W'(arpc_pkg::TABLE_ENTRIES))
    |=> (count_q == $past(count_q) + 1'b1 && out_valid_q))
    else $error("append did not bump entry count");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (st_q == S_IDLE && (!out_valid_q || out_ready_i)))
    else $error("command popped while busy");

endmodule

### rtl/arp_responder_with_cache_core.sv
// arp_responder_with_cache_core: top level, classifier front, queue, cache engine
// depends on arpc_pkg, arpc_front, arpc_queue, arpc_back
//
// channel   direction  handshake               beat
// cfg       in         cfg_we_i                cfg_idx_i, cfg_wdata_i
// in        in         in_valid_i/in_ready_o   opcode, proto_type, sender mac/ip, target ip
// out       out        out_valid_o/out_ready_i send_reply, reply dest mac/ip, status, index
//
// ignored packet: goes from idle straight to the result register; learning scans the valid
// entries in turn until a hit, then the miss state on a miss (one memory read and compare per entry)
// the queue takes two packets while the engine works or a result waits
// reset empties the cache (entry count zero) and clears own_ip; no clearing pass
// the engine starts a packet only when the result register is free

module arp_responder_with_cache_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [arpc_pkg::CFG_DAT_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [arpc_pkg::OPCODE_W-1:0]    opcode_i,
  input  logic [arpc_pkg::PTYPE_W-1:0]     proto_type_i,
  input  logic [arpc_pkg::MAC_W-1:0]       sender_mac_i,
  input  logic [arpc_pkg::IP_W-1:0]        sender_ip_i,
  input  logic [arpc_pkg::IP_W-1:0]        target_ip_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             send_reply_o,
  output logic [arpc_pkg::MAC_W-1:0]       reply_dest_mac_o,
  output logic [arpc_pkg::IP_W-1:0]        reply_dest_ip_o,
  output logic [arpc_pkg::STATUS_W-1:0]    table_status_o,
  output logic [arpc_pkg::ENTRY_W-1:0]     entry_index_o
);

  logic           q_full, q_push, q_pop, q_valid;
  arpc_pkg::cmd_t push_cmd, pop_cmd;
  arpc_pkg::res_t res;

  arpc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .proto_type_i (proto_type_i),
    .sender_mac_i (sender_mac_i),
    .sender_ip_i  (sender_ip_i),
    .target_ip_i  (target_ip_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (push_cmd)
  );

  arpc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (pop_cmd)
  );

  arpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (pop_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign send_reply_o     = res.send_reply;
  assign reply_dest_mac_o = res.dest_mac;
  assign reply_dest_ip_o  = res.dest_ip;
  assign table_status_o   = res.status;
  assign entry_index_o    = res.entry_index;

endmodule

### tb/sv/arpc_reply_checker.sv
// arpc_reply_checker: watches the cfg, in and out channels of the arp responder,
// keeps its own cache copy, predicts each result beat and compares it field by field
// depends on arpc_pkg

module arpc_reply_checker
  import arpc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [OPCODE_W-1:0]  opcode_i,
  input  logic [PTYPE_W-1:0]   proto_type_i,
  input  logic [MAC_W-1:0]     sender_mac_i,
  input  logic [IP_W-1:0]      sender_ip_i,
  input  logic [IP_W-1:0]      target_ip_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 send_reply_i,
  input  logic [MAC_W-1:0]     reply_dest_mac_i,
  input  logic [IP_W-1:0]      reply_dest_ip_i,
  input  logic [STATUS_W-1:0]  table_status_i,
  input  logic [ENTRY_W-1:0]   entry_index_i,
  output int                   err_count_o,
  output int                   pending_o
);

  localparam int MAX_PRINTS = 200;

  logic [MAC_W-1:0] cache_mac_q [TABLE_ENTRIES];
  logic [IP_W-1:0]  cache_ip_q  [TABLE_ENTRIES];
  int               entry_cnt_q;
  logic [IP_W-1:0]  own_ip_q;
  logic [MAC_W-1:0] own_mac_q;
  res_t             outcome_q [$];
  res_t             oldest;

  task automatic report_mismatch(input string msg);
    err_count_o++;
    if (err_count_o <= MAX_PRINTS) begin
      $display("[%0t] arp check: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      report_mismatch($sformatf("%s expected %h got %h", name, exp_v, got_v));
    end
  endtask

  // search valid entries by mac: hit overwrites ip, miss appends, full drops
  function automatic void learn_pair(input logic [MAC_W-1:0] mac, input logic [IP_W-1:0] ip,
                                     output table_status_e st,
                                     output logic [ENTRY_W-1:0] slot);
    for (int i = 0; i < entry_cnt_q; i++) begin
      if (cache_mac_q[i] == mac) begin
        cache_ip_q[i] = ip;
        st = ST_UPDATED;
        slot = i[ENTRY_W-1:0];
        return;
      end
    end
    if (entry_cnt_q < TABLE_ENTRIES) begin
      cache_mac_q[entry_cnt_q] = mac;
      cache_ip_q[entry_cnt_q] = ip;
      st = ST_ADDED;
      slot = entry_cnt_q[ENTRY_W-1:0];
      entry_cnt_q++;
      return;
    end
    st = ST_FULL;
    slot = '0;
  endfunction

  function automatic res_t resolve_packet(input logic [OPCODE_W-1:0] op,
                                          input logic [PTYPE_W-1:0] pt,
                                          input logic [MAC_W-1:0] smac,
                                          input logic [IP_W-1:0] sip,
                                          input logic [IP_W-1:0] tip);
    res_t               r;
    table_status_e      st;
    logic [ENTRY_W-1:0] slot;
    r = '0;
    if (op == OP_REQUEST) begin
      if (pt == ETHERTYPE_IPV4 && tip == own_ip_q) begin
        learn_pair(smac, sip, st, slot);
        r.status = st;
        r.entry_index = slot;
        r.send_reply = 1'b1;
        r.dest_mac = smac;
        r.dest_ip = sip;
      end
    end else if (op == OP_REPLY) begin
      // replies teach the cache without any type or target check
      learn_pair(smac, sip, st, slot);
      r.status = st;
      r.entry_index = slot;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_cnt_q = 0;
      own_ip_q = '0;
      own_mac_q = '0;
      outcome_q.delete();
      err_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OWN_IP:  own_ip_q = cfg_wdata_i[IP_W-1:0];
          CFG_OWN_MAC: own_mac_q = cfg_wdata_i[MAC_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        outcome_q.push_back(resolve_packet(opcode_i, proto_type_i, sender_mac_i,
                                           sender_ip_i, target_ip_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result beat with nothing predicted");
        end else begin
          oldest = outcome_q.pop_front();
          check_field("send_reply", 64'(oldest.send_reply), 64'(send_reply_i));
          check_field("reply_dest_mac", 64'(oldest.dest_mac), 64'(reply_dest_mac_i));
          check_field("reply_dest_ip", 64'(oldest.dest_ip), 64'(reply_dest_ip_i));
          check_field("table_status", 64'(oldest.status), 64'(table_status_i));
          check_field("entry_index", 64'(oldest.entry_index), 64'(entry_index_i));
        end
      end
      pending_o = outcome_q.size();
    end
  end

endmodule

### tb/sv/arp_responder_with_cache_core_tb.sv
// arp_responder_with_cache_core_tb: clock, reset, packet and register stimulus, verdict
// depends on arpc_pkg, arp_responder_with_cache_core and arpc_reply_checker

module arp_responder_with_cache_core_tb;
  import arpc_pkg::*;

  localparam int LIMIT       = 400000;
  localparam int SETTLE      = 40;
  localparam int PHASE_ITEMS = 190;
  localparam int POOL_SIZE   = 20;

  localparam logic [OPCODE_W-1:0] OP_ZERO     = 8'h00;
  localparam logic [OPCODE_W-1:0] OP_RARP_REQ = 8'h03;
  localparam logic [OPCODE_W-1:0] OP_MAX      = 8'hff;
  localparam logic [PTYPE_W-1:0]  PT_IPV6     = 16'h86dd;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DAT_W-1:0] cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [OPCODE_W-1:0]  opcode_i;
  logic [PTYPE_W-1:0]   proto_type_i;
  logic [MAC_W-1:0]     sender_mac_i;
  logic [IP_W-1:0]      sender_ip_i;
  logic [IP_W-1:0]      target_ip_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 send_reply_o;
  logic [MAC_W-1:0]     reply_dest_mac_o;
  logic [IP_W-1:0]      reply_dest_ip_o;
  logic [STATUS_W-1:0]  table_status_o;
  logic [ENTRY_W-1:0]   entry_index_o;

  int               err_count;
  int               pending;
  int               cycle_cnt;
  logic             calm;
  logic [IP_W-1:0]  cur_own_ip;
  logic [MAC_W-1:0] mac_pool [POOL_SIZE];

  always #2 clk_i = ~clk_i;

  arp_responder_with_cache_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .proto_type_i     (proto_type_i),
    .sender_mac_i     (sender_mac_i),
    .sender_ip_i      (sender_ip_i),
    .target_ip_i      (target_ip_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .send_reply_o     (send_reply_o),
    .reply_dest_mac_o (reply_dest_mac_o),
    .reply_dest_ip_o  (reply_dest_ip_o),
    .table_status_o   (table_status_o),
    .entry_index_o    (entry_index_o)
  );

  arpc_reply_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .opcode_i         (opcode_i),
    .proto_type_i     (proto_type_i),
    .sender_mac_i     (sender_mac_i),
    .sender_ip_i      (sender_ip_i),
    .target_ip_i      (target_ip_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .send_reply_i     (send_reply_o),
    .reply_dest_mac_i (reply_dest_mac_o),
    .reply_dest_ip_i  (reply_dest_ip_o),
    .table_status_i   (table_status_o),
    .entry_index_i    (entry_index_o),
    .err_count_o      (err_count),
    .pending_o        (pending)
  );

  // receiver stalls in about 9 percent of cycles, never while calm
  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 9);
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[MAC_W-1:0];
  endfunction

  function automatic logic [MAC_W-1:0] pick_mac();
    if ($urandom_range(0, 99) < 75) begin
      return mac_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    return rand_mac();
  endfunction

  function automatic logic [IP_W-1:0] pick_ip();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      return '0;
    end else if (k == 1) begin
      return '1;
    end
    return $urandom();
  endfunction

  // called at a falling edge; returns at a falling edge with valid possibly still high
  task automatic send_packet(input logic [OPCODE_W-1:0] op, input logic [PTYPE_W-1:0] pt,
                             input logic [MAC_W-1:0] smac, input logic [IP_W-1:0] sip,
                             input logic [IP_W-1:0] tip);
    opcode_i <= op;
    proto_type_i <= pt;
    sender_mac_i <= smac;
    sender_ip_i <= sip;
    target_ip_i <= tip;
    in_valid_i <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // block is idle here: both registers written back to back
  task automatic apply_settings(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_OWN_IP;
    cfg_wdata_i <= {{(CFG_DAT_W - IP_W){1'b0}}, ip};
    @(negedge clk_i);
    cfg_idx_i <= CFG_OWN_MAC;
    cfg_wdata_i <= mac;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_own_ip = ip;
    @(negedge clk_i);
  endtask

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [OPCODE_W-1:0] op;
    logic [PTYPE_W-1:0]  pt;
    logic [IP_W-1:0]     tip;
    logic [IP_W-1:0]     phase_ip;
    logic [MAC_W-1:0]    phase_mac;
    int unsigned         kind;
    int                  learned;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_OWN_IP;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    opcode_i = '0;
    proto_type_i = '0;
    sender_mac_i = '0;
    sender_ip_i = '0;
    target_ip_i = '0;
    out_ready_i = 1'b0;
    calm = 1'b0;
    cur_own_ip = '0;
    mac_pool[0] = '0;
    mac_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) mac_pool[i] = rand_mac();

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // own_ip is zero out of reset
    send_packet(OP_REQUEST, ETHERTYPE_IPV4, mac_pool[0], '0, '0);
    send_packet(OP_REQUEST, ETHERTYPE_IPV4, mac_pool[1], '1, '0);
    // reply learns regardless of type and target
    send_packet(OP_REPLY, '1, mac_pool[0], $urandom(), '1);
    send_packet(OP_REQUEST, PT_IPV6, rand_mac(), $urandom(), '0);
    send_packet(OP_REQUEST, ETHERTYPE_IPV4, rand_mac(), $urandom(), '1);
    send_packet(OP_ZERO, ETHERTYPE_IPV4, rand_mac(), $urandom(), '0);
    send_packet(OP_MAX, ETHERTYPE_IPV4, rand_mac(), $urandom(), '0);
    send_packet(OP_RARP_REQ, '0, rand_mac(), $urandom(), '0);
    for (int i = 2; i < TABLE_ENTRIES; i++) begin
      send_packet(OP_REPLY, ETHERTYPE_IPV4, mac_pool[i], $urandom(), $urandom());
    end
    // table is full now: new macs are dropped, known ones still update
    send_packet(OP_REPLY, ETHERTYPE_IPV4, mac_pool[16], $urandom(), $urandom());
    send_packet(OP_REQUEST, ETHERTYPE_IPV4, mac_pool[17], $urandom(), '0);
    send_packet(OP_REPLY, '0, mac_pool[TABLE_ENTRIES - 1], '0, '0);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          phase_ip = '1;
          phase_mac = '1;
        end
        1: begin
          phase_ip = $urandom();
          phase_mac = '0;
        end
        2: begin
          phase_ip = '0;
          phase_mac = rand_mac();
        end
        default: begin
          phase_ip = $urandom();
          phase_mac = rand_mac();
        end
      endcase
      apply_settings(phase_ip, phase_mac);
      learned = 0;
      while (learned < PHASE_ITEMS) begin
        calm = (phase == 1) && (learned >= 50) && (learned < 200);
        kind = $urandom_range(0, 99);
        tip = $urandom();
        pt = 16'($urandom());
        if (kind < 45) begin
          op = OP_REQUEST;
          pt = ETHERTYPE_IPV4;
          tip = cur_own_ip;
        end else if (kind < 75) begin
          op = OP_REPLY;
          if ($urandom_range(0, 1) == 0) pt = ETHERTYPE_IPV4;
        end else if (kind < 87) begin
          // broken request: wrong type or a target one bit off
          op = OP_REQUEST;
          if ($urandom_range(0, 1) == 0) begin
            tip = cur_own_ip;
          end else begin
            pt = ETHERTYPE_IPV4;
            tip = cur_own_ip ^ (32'd1 << $urandom_range(0, IP_W - 1));
          end
        end else begin
          op = 8'($urandom_range(0, 255));
        end
        if (op == OP_REPLY ||
            (op == OP_REQUEST && pt == ETHERTYPE_IPV4 && tip == cur_own_ip)) begin
          learned++;
        end
        send_packet(op, pt, pick_mac(), pick_ip(), tip);
        if (learned == PHASE_ITEMS / 2) begin
          drain_results();
          learned++;
        end
      end
      calm = 1'b0;
      drain_results();
    end

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
